>>> hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define CFLP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cflp assertion failed");

// clocked assertion that also holds during reset
`define CFLP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cflp assertion failed");

`endif

>>> hdl/cflp_pkg.sv
// shared constants, types and states of the flag liveness pruner
package cflp_pkg;

    localparam int MAX_INSNS = 32;
    localparam int FLAG_BITS = 4;
    localparam int IDX_W     = $clog2(MAX_INSNS);
    localparam int CNT_W     = IDX_W + 1;
    localparam logic [FLAG_BITS-1:0] FLAG_ALL = {FLAG_BITS{1'b1}};

    typedef struct packed {
        logic [FLAG_BITS-1:0] tflags;
        logic                 found;
        logic                 direct;
        logic                 pc;
        logic [FLAG_BITS-1:0] written;
        logic [FLAG_BITS-1:0] used;
    } attrs_t;

    typedef struct packed {
        attrs_t      attrs;
        logic [31:0] target;
        logic [31:0] addr;
    } insn_row_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_req_t;

    typedef enum logic [5:0] {
        ST_LOAD = 6'b000001,
        ST_RD   = 6'b000010,
        ST_EVAL = 6'b000100,
        ST_TGT  = 6'b001000,
        ST_ORD  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

endpackage

>>> hdl/cflp_insn_mem.sv
// instruction store: one write port, two registered read ports
module cflp_insn_mem (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [cflp_pkg::IDX_W-1:0] wr_addr,
    input  cflp_pkg::insn_row_t        wr_row,
    input  cflp_pkg::rd_req_t          rd_a,
    input  cflp_pkg::rd_req_t          rd_b,
    output cflp_pkg::insn_row_t        row_a,
    output cflp_pkg::insn_row_t        row_b
);

    cflp_pkg::insn_row_t mem [cflp_pkg::MAX_INSNS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_a.en)
        begin
            row_a <= mem[rd_a.addr];
        end
        if (rd_b.en)
        begin
            row_b <= mem[rd_b.addr];
        end
    end

endmodule

>>> hdl/cflp_live_mem.sv
// per-instruction entry liveness store, registered read
module cflp_live_mem (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [cflp_pkg::IDX_W-1:0]     wr_addr,
    input  logic [cflp_pkg::FLAG_BITS-1:0] wr_data,
    input  cflp_pkg::rd_req_t              rd,
    output logic [cflp_pkg::FLAG_BITS-1:0] rd_data
);

    logic [cflp_pkg::FLAG_BITS-1:0] mem [cflp_pkg::MAX_INSNS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

>>> hdl/condition_flag_liveness_pruner.sv
// top level: loads a block, walks it backward over the stores, emits pruned results
//
//  channel  dir  handshake                  payload
//  s_*      in   s_tvalid / s_tready        s_tdata (79 bits used), s_tlast = last_insn
//  m_*      out  m_tvalid / m_tready        m_tdata (15 bits used), m_tlast = last_result
//  cfg_*    in   cfg_wr_en                  cfg_wr_data = half-word step (2-byte insns)
//
// loading accepts one instruction per cycle; the block then walks backward through the
// instruction store, reading then evaluating each instruction and checking the target
// where a branch target's liveness must be fetched, once or twice (a backward in-block
// branch adds a pass); emission reads each result in ST_ORD and holds it in ST_OUT while m_tready is low
// s_tready is high only while loading, so no new transaction enters during analysis
// reset clears the control state; the stores need no clearing since every read entry
// is written earlier in the same block
module condition_flag_liveness_pruner (
    input  logic        clk,
    input  logic        rst_n,
    // guest_address[31:0] flags_used[35:32] flags_written[39:36] changes_pc[40]
    // direct_branch[41] branch_target[73:42] target_block_found[74]
    // target_block_flags[78:75]
    input  logic [79:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    // insn_index[5:0] pruned_flags_written[9:6] entry_valid[10] entry_flags[14:11]
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    output logic        m_tlast,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    localparam int IW = cflp_pkg::IDX_W;
    localparam int CW = cflp_pkg::CNT_W;
    localparam int FW = cflp_pkg::FLAG_BITS;

    cflp_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [FW-1:0]  live_reg, live_next;
    logic           pass2_reg, pass2_next;
    logic           again_reg, again_next;
    logic           thumb_reg;
    logic           prev_pc_reg, prev_pc_next;
    logic [31:0]    start_reg, start_next;
    logic [31:0]    last_addr_reg, last_addr_next;
    logic [31:0]    dest_reg, dest_next;
    logic           tgt_ok_reg, tgt_ok_next;

    // store ports
    logic                ins_wr_en;
    logic [IW-1:0]       ins_wr_addr;
    cflp_pkg::insn_row_t ins_wr_row;
    cflp_pkg::rd_req_t   rd_a, rd_b, live_rd;
    cflp_pkg::insn_row_t row_a, row_b;
    logic                live_wr_en;
    logic [IW-1:0]       live_wr_addr;
    logic [FW-1:0]       live_wr_data;
    logic [FW-1:0]       live_q;

    cflp_insn_mem u_insn_mem (
        .clk     (clk),
        .wr_en   (ins_wr_en),
        .wr_addr (ins_wr_addr),
        .wr_row  (ins_wr_row),
        .rd_a    (rd_a),
        .rd_b    (rd_b),
        .row_a   (row_a),
        .row_b   (row_b)
    );

    cflp_live_mem u_live_mem (
        .clk     (clk),
        .wr_en   (live_wr_en),
        .wr_addr (live_wr_addr),
        .wr_data (live_wr_data),
        .rd      (live_rd),
        .rd_data (live_q)
    );

    // incoming transaction unpacked into a store row
    cflp_pkg::insn_row_t in_row;
    always_comb
    begin
        in_row.addr          = s_tdata[31:0];
        in_row.attrs.used    = s_tdata[35:32];
        in_row.attrs.written = s_tdata[39:36];
        in_row.attrs.pc      = s_tdata[40];
        in_row.attrs.direct  = s_tdata[41];
        in_row.target        = s_tdata[73:42];
        in_row.attrs.found   = s_tdata[74];
        in_row.attrs.tflags  = s_tdata[78:75];
    end

    // evaluation of the row read for the current instruction
    cflp_pkg::attrs_t attrs;
    logic [FW-1:0] gen, live_k;
    logic [31:0]   dest, addr, diff, span, blk_end;
    logic          fwd, in_blk, fwd_ok, bwd_ok;
    logic [CW-1:0] remain;
    logic [IW-1:0] tgt_idx;

    assign attrs   = row_a.attrs;
    assign gen     = live_reg & attrs.written;
    // a reader adds its flags and kills nothing, otherwise live writes are killed
    assign live_k  = (attrs.used != '0) ? (live_reg | attrs.used) : (live_reg & ~gen);
    assign dest    = row_a.target;
    assign addr    = row_a.addr;
    assign fwd     = dest > addr;
    assign diff    = fwd ? (dest - addr) : (addr - dest);
    assign span    = thumb_reg ? (diff >> 1) : (diff >> 2);
    assign blk_end = last_addr_reg + 32'd1;
    // a wrapped end address leaves no target in the block
    assign in_blk  = (dest >= start_reg) && (dest < blk_end);
    assign remain  = cnt_reg - {1'b0, idx_reg};
    assign fwd_ok  = span < {{(32-CW){1'b0}}, remain};
    assign bwd_ok  = span <= {{(32-IW){1'b0}}, idx_reg};
    assign tgt_idx = fwd ? (idx_reg + span[IW-1:0]) : (idx_reg - span[IW-1:0]);

    logic          fin;
    logic [FW-1:0] fin_live;
    logic          again_set;
    logic          again_any;
    logic [CW-1:0] cnt_last;

    assign cnt_last = cnt_reg - CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        live_next      = live_reg;
        pass2_next     = pass2_reg;
        again_next     = again_reg;
        prev_pc_next   = prev_pc_reg;
        start_next     = start_reg;
        last_addr_next = last_addr_reg;
        dest_next      = dest_reg;
        tgt_ok_next    = tgt_ok_reg;
        ins_wr_en      = 1'b0;
        ins_wr_addr    = idx_reg;
        ins_wr_row     = in_row;
        rd_a           = '{en: 1'b0, addr: idx_reg};
        rd_b           = '{en: 1'b0, addr: tgt_idx};
        live_rd        = '{en: 1'b0, addr: tgt_idx};
        live_wr_en     = 1'b0;
        live_wr_addr   = idx_reg;
        live_wr_data   = live_reg;
        fin            = 1'b0;
        fin_live       = live_reg;
        again_set      = 1'b0;
        again_any      = again_reg;

        case (state_reg)
            cflp_pkg::ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    ins_wr_en      = 1'b1;
                    ins_wr_addr    = cnt_reg[IW-1:0];
                    cnt_next       = cnt_reg + CW'(1);
                    last_addr_next = in_row.addr;
                    if (cnt_reg == '0)
                    begin
                        start_next = in_row.addr;
                    end
                    // a full store ends the block as if tlast were set
                    if (s_tlast || (cnt_reg == CW'(cflp_pkg::MAX_INSNS - 1)))
                    begin
                        idx_next   = cnt_reg[IW-1:0];
                        live_next  = cflp_pkg::FLAG_ALL;
                        pass2_next = 1'b0;
                        again_next = 1'b0;
                        state_next = cflp_pkg::ST_RD;
                    end
                end
            end
            cflp_pkg::ST_RD:
            begin
                rd_a.en    = 1'b1;
                state_next = cflp_pkg::ST_EVAL;
            end
            cflp_pkg::ST_EVAL:
            begin
                // write back the pruned write mask
                ins_wr_en                  = 1'b1;
                ins_wr_row                 = row_a;
                ins_wr_row.attrs.written   = gen;
                rd_b.en                    = 1'b1;
                live_rd.en                 = 1'b1;
                if (attrs.pc && attrs.direct && in_blk && (fwd || pass2_reg))
                begin
                    tgt_ok_next = fwd ? fwd_ok : bwd_ok;
                    dest_next   = dest;
                    live_next   = live_k;
                    state_next  = cflp_pkg::ST_TGT;
                end
                else
                begin
                    fin = 1'b1;
                    if (!attrs.pc)
                    begin
                        fin_live = live_k;
                    end
                    else if (!attrs.direct)
                    begin
                        fin_live = cflp_pkg::FLAG_ALL;
                    end
                    else if (in_blk)
                    begin
                        // backward branch on the first pass
                        fin_live  = cflp_pkg::FLAG_ALL;
                        again_set = 1'b1;
                    end
                    else if (attrs.found)
                    begin
                        fin_live = live_k | attrs.tflags;
                    end
                    else
                    begin
                        fin_live = cflp_pkg::FLAG_ALL;
                    end
                end
            end
            cflp_pkg::ST_TGT:
            begin
                fin = 1'b1;
                // target out of range or off an instruction boundary makes all flags live
                if (tgt_ok_reg && (row_b.addr == dest_reg))
                begin
                    fin_live = live_reg | live_q;
                end
                else
                begin
                    fin_live = cflp_pkg::FLAG_ALL;
                end
            end
            cflp_pkg::ST_ORD:
            begin
                rd_a.en      = 1'b1;
                live_rd.en   = 1'b1;
                live_rd.addr = idx_reg;
                state_next   = cflp_pkg::ST_OUT;
            end
            cflp_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    prev_pc_next = attrs.pc;
                    if ({1'b0, idx_reg} == cnt_last)
                    begin
                        cnt_next   = '0;
                        state_next = cflp_pkg::ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = cflp_pkg::ST_ORD;
                    end
                end
            end
            default:
            begin
                state_next = cflp_pkg::ST_LOAD;
            end
        endcase

        // close one instruction of the backward walk
        if (fin)
        begin
            again_any    = again_reg | again_set;
            again_next   = again_any;
            live_wr_en   = 1'b1;
            live_wr_data = fin_live;
            live_next    = fin_live;
            if (idx_reg == '0)
            begin
                if (!pass2_reg && again_any)
                begin
                    pass2_next = 1'b1;
                    idx_next   = cnt_last[IW-1:0];
                    live_next  = cflp_pkg::FLAG_ALL;
                    state_next = cflp_pkg::ST_RD;
                end
                else
                begin
                    idx_next     = '0;
                    prev_pc_next = 1'b0;
                    state_next   = cflp_pkg::ST_ORD;
                end
            end
            else
            begin
                idx_next   = idx_reg - IW'(1);
                state_next = cflp_pkg::ST_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cflp_pkg::ST_LOAD;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            live_reg    <= cflp_pkg::FLAG_ALL;
            pass2_reg   <= 1'b0;
            again_reg   <= 1'b0;
            prev_pc_reg <= 1'b0;
            thumb_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            live_reg    <= live_next;
            pass2_reg   <= pass2_next;
            again_reg   <= again_next;
            prev_pc_reg <= prev_pc_next;
            if (cfg_wr_en)
            begin
                thumb_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        last_addr_reg <= last_addr_next;
        dest_reg      <= dest_next;
        tgt_ok_reg    <= tgt_ok_next;
    end

    // result transaction, straight from the registered store outputs
    logic entry;
    assign entry    = (idx_reg == '0) || prev_pc_reg;
    assign s_tready = (state_reg == cflp_pkg::ST_LOAD);
    assign m_tvalid = (state_reg == cflp_pkg::ST_OUT);
    assign m_tlast  = ({1'b0, idx_reg} == cnt_last);
    assign m_tdata  = {1'b0,
                       (entry ? live_q : {FW{1'b0}}),
                       entry,
                       attrs.written,
                       {{(6-IW){1'b0}}, idx_reg}};

endmodule

>>> hdl/cflp_checker.sv
// port-level checker for the flag liveness pruner, bound to the top level
`include "assert_macros.svh"

module cflp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic [15:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tlast,
    input logic        m_tready
);

    // loading and emission never overlap
    `CFLP_ASSERT(a_no_overlap, !(s_tready && m_tvalid))
    // a stalled result holds
    `CFLP_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    // the first instruction always carries entry liveness
    `CFLP_ASSERT(a_entry0, (m_tvalid && (m_tdata[5:0] == 6'd0)) |-> m_tdata[10])
    // after the final result the block is back to loading
    `CFLP_ASSERT(a_back_to_load, (m_tvalid && m_tready && m_tlast) |=> s_tready)
    // no output during reset
    `CFLP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid)

endmodule

bind condition_flag_liveness_pruner cflp_checker u_cflp_checker (.*);

>>> test/condition_flag_liveness_pruner_test.sv
// testbench for the condition flag liveness pruner: block loading, backward pruning, entry liveness
module condition_flag_liveness_pruner_test;
    import cflp_pkg::*;

    // one analysed instruction as the testbench keeps it
    typedef struct {
        logic [31:0]          addr;
        logic [31:0]          target;
        logic [FLAG_BITS-1:0] used;
        logic [FLAG_BITS-1:0] written;
        logic                 pc;
        logic                 direct;
        logic                 found;
        logic [FLAG_BITS-1:0] tflags;
        logic                 last;
    } insn_t;

    // one expected result transaction
    typedef struct {
        logic [5:0]           index;
        logic [FLAG_BITS-1:0] pruned;
        logic                 entry_valid;
        logic [FLAG_BITS-1:0] entry_flags;
        logic                 last;
    } prune_result_t;

    int error_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // scoreboard: collects a block, predicts its pruned results, checks the output stream
    class prune_scoreboard;
        insn_t          block_insns[$];
        prune_result_t  pending_results[$];
        bit             thumb;

        // backward liveness walk over the collected block
        function void predict_block();
            int n;
            logic [31:0] first_addr, end_addr, dest;
            logic [FLAG_BITS-1:0] live, gen, nf;
            logic [FLAG_BITS-1:0] pruned [MAX_INSNS];
            logic [FLAG_BITS-1:0] live_in [MAX_INSNS];
            int shift, d;
            bit again;
            prune_result_t r;
            n = block_insns.size();
            first_addr = block_insns[0].addr;
            end_addr = block_insns[n-1].addr + 32'd1;
            shift = thumb ? 1 : 2;
            for (int i = 0; i < n; i++)
            begin
                pruned[i] = block_insns[i].written;
                live_in[i] = '0;
            end
            for (int pass = 1; pass <= 2; pass++)
            begin
                again = 0;
                live = FLAG_ALL;
                for (int i = n - 1; i >= 0; i--)
                begin
                    gen = live & pruned[i];
                    pruned[i] = gen;
                    if (block_insns[i].used != 0)
                        live |= block_insns[i].used;
                    else
                        live &= ~gen;
                    if (block_insns[i].pc)
                    begin
                        if (block_insns[i].direct)
                        begin
                            dest = block_insns[i].target;
                            if (dest >= first_addr && dest < end_addr)
                            begin
                                nf = FLAG_ALL;
                                if (dest > block_insns[i].addr)
                                begin
                                    d = int'((dest - block_insns[i].addr) >> shift);
                                    // unsigned compare against remaining length
                                    if (((dest - block_insns[i].addr) >> shift) < (n - i)
                                        && block_insns[i+d].addr == dest)
                                        nf = live_in[i+d];
                                    live |= nf;
                                end
                                else if (pass == 1)
                                begin
                                    again = 1;
                                    live = FLAG_ALL;
                                end
                                else
                                begin
                                    if (((block_insns[i].addr - dest) >> shift) <= i)
                                    begin
                                        d = int'((block_insns[i].addr - dest) >> shift);
                                        if (block_insns[i-d].addr == dest)
                                            nf = live_in[i-d];
                                    end
                                    live |= nf;
                                end
                            end
                            else if (block_insns[i].found)
                                live |= block_insns[i].tflags;
                            else
                                live = FLAG_ALL;
                        end
                        else
                            live = FLAG_ALL;
                    end
                    live_in[i] = live;
                end
                if (!again)
                    break;
            end
            for (int i = 0; i < n; i++)
            begin
                r.index = i[5:0];
                r.pruned = pruned[i];
                r.entry_valid = (i == 0) || block_insns[i-1].pc;
                r.entry_flags = r.entry_valid ? live_in[i] : '0;
                r.last = (i == n - 1);
                pending_results.push_back(r);
            end
            block_insns.delete();
        endfunction

        function void note_insn(insn_t insn);
            block_insns.push_back(insn);
            if (insn.last || block_insns.size() >= MAX_INSNS)
                predict_block();
        endfunction

        task check_result(logic [15:0] data, logic last);
            prune_result_t e;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", data, 0);
                return;
            end
            e = pending_results.pop_front();
            if (data[5:0] != e.index) report_mismatch("insn_index", data[5:0], e.index);
            if (data[9:6] != e.pruned) report_mismatch("pruned_flags_written", data[9:6], e.pruned);
            if (data[10] != e.entry_valid) report_mismatch("entry_valid", data[10], e.entry_valid);
            if (data[14:11] != e.entry_flags)
                report_mismatch("entry_flags", data[14:11], e.entry_flags);
            if (last != e.last) report_mismatch("last_result", last, e.last);
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 1;
    logic [79:0] s_tdata = '0;
    logic        s_tvalid = 0;
    logic        s_tlast = 0;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tlast;
    logic        m_tready = 0;
    logic        cfg_wr_en = 0;
    logic        cfg_wr_data = 0;

    prune_scoreboard board = new();

    // idle percentages per side, changed between phases
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    bit hold_off_req = 0;
    bit hold_off_done = 0;
    int quiet_cycles = 0;
    int current_block_len = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    condition_flag_liveness_pruner uut (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tlast(s_tlast), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tlast(m_tlast), .m_tready(m_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // result side: sample at the rising edge, change ready at the falling edge
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tlast);

    // a long hold-off, once requested, is counted here
    always @(negedge clk)
    begin
        if (hold_off_req && !hold_off_done)
        begin
            hold_off_done <= 1;
            hold_off_cycles <= 400;
            m_tready <= 0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: counts cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("condition_flag_liveness_pruner_test failed");
            $finish;
        end
    end

    // one instruction transaction, with random idle cycles before it
    task automatic send_insn(insn_t insn);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tdata <= {1'b0, insn.tflags, insn.found, insn.target, insn.direct, insn.pc,
                    insn.written, insn.used, insn.addr};
        s_tlast <= insn.last;
        s_tvalid <= 1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_insn(insn);
        @(negedge clk);
    endtask

    // wait until all results are in, then let the block settle before a register write
    task automatic drain_and_settle();
        s_tvalid <= 0;
        while (board.pending_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_mode(bit mode);
        drain_and_settle();
        cfg_wr_en <= 1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en <= 0;
        board.thumb = mode;
    endtask

    // random well-formed block: sequential addresses, branches mostly in-block
    task automatic send_block(int len, bit wrap_base);
        insn_t insn;
        logic [31:0] base;
        int step, tgt;
        step = board.thumb ? 2 : 4;
        base = wrap_base ? (32'hFFFF_FFFF - (len - 1) * step) : ($urandom() & 32'hFFFF_FFFC);
        if ($urandom_range(9) == 0)
            base = $urandom();
        for (int i = 0; i < len; i++)
        begin
            insn.addr = base + i * step;
            insn.used = ($urandom_range(2) == 0) ? 4'($urandom()) : 4'h0;
            insn.written = 4'($urandom());
            insn.pc = ($urandom_range(3) == 0);
            insn.direct = ($urandom_range(4) != 0);
            tgt = $urandom_range(len - 1);
            case ($urandom_range(5))
                0: insn.target = $urandom();
                1: insn.target = base + tgt * step + 1;
                default: insn.target = base + tgt * step;
            endcase
            insn.found = 1'($urandom());
            insn.tflags = 4'($urandom());
            insn.last = (i == len - 1);
            send_insn(insn);
        end
    endtask

    task automatic send_one(logic [31:0] addr, logic [3:0] used, logic [3:0] written,
                            logic pc, logic direct, logic [31:0] target, logic found,
                            logic [3:0] tflags, logic last);
        insn_t insn;
        insn.addr = addr; insn.used = used; insn.written = written; insn.pc = pc;
        insn.direct = direct; insn.target = target; insn.found = found;
        insn.tflags = tflags; insn.last = last;
        send_insn(insn);
    endtask

    initial
    begin
        int items;
        rst_n = 0;
        board.thumb = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: forward branch, backward branch, out-of-block found and not, indirect
        send_one(32'h1000, 4'h0, 4'hF, 1, 1, 32'h1008, 0, 4'h0, 0);
        send_one(32'h1004, 4'h3, 4'hF, 0, 0, 32'h0, 0, 4'h0, 0);
        send_one(32'h1008, 4'h0, 4'hA, 1, 1, 32'h1000, 0, 4'h0, 0);
        send_one(32'h100C, 4'h0, 4'h5, 1, 1, 32'h9000, 1, 4'h6, 0);
        send_one(32'h1010, 4'h0, 4'hF, 1, 1, 32'h9000, 0, 4'h9, 0);
        send_one(32'h1014, 4'hF, 4'hF, 1, 0, 32'hFFFF_FFFF, 1, 4'hF, 1);
        // misaligned in-block target, then address wrap at the top of memory
        send_one(32'h2000, 4'h0, 4'hF, 1, 1, 32'h2002, 0, 4'h0, 0);
        send_one(32'h2004, 4'h0, 4'hF, 0, 0, 32'h0, 0, 4'h0, 1);
        send_one(32'hFFFF_FFFC, 4'h0, 4'hF, 1, 1, 32'hFFFF_FFFC, 1, 4'h2, 0);
        send_one(32'hFFFF_FFFF, 4'h0, 4'hF, 0, 0, 32'hFFFF_FFFF, 0, 4'h0, 1);
        // full-size block, with tlast on its last instruction, then a one-instruction block
        send_block(MAX_INSNS, 0);
        send_one(32'h0, 4'h0, 4'h0, 0, 0, 32'h0, 0, 4'h0, 1);
        write_mode(1);
        send_block(5, 1);
        send_one(32'h3000, 4'h0, 4'hC, 1, 1, 32'h3000, 0, 4'h0, 1);

        // random phases: none, sender idle, receiver stall, both
        items = 0;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            write_mode(phase % 3 == 1);
            if (phase == 4)
                hold_off_req = 1;
            while (items < (phase + 1) * 48)
            begin
                current_block_len = ($urandom_range(15) == 0) ? MAX_INSNS : $urandom_range(1, 8);
                send_block(current_block_len, $urandom_range(19) == 0);
                items += current_block_len;
            end
        end

        drain_and_settle();
        if (error_count == 0)
            $display("condition_flag_liveness_pruner_test passed");
        else
            $display("condition_flag_liveness_pruner_test failed");
        $finish;
    end
endmodule
